// ===== hw/rtl/srb_pkg.sv =====
package srb_pkg;

   localparam int DEPTH       = 16;
   localparam int MAX_PAYLOAD = 1024;
   localparam int SEQ_BITS    = 32;
   localparam int LEN_W       = 11;
   localparam int HANDLE_W    = 4;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int STATUS_W    = 2;

   // request tdata layout, lowest bit first: seq, length, payload_handle
   localparam int REQ_DATA_W  = 48;
   localparam int REQ_SEQ_LO  = 0;
   localparam int REQ_LEN_LO  = REQ_SEQ_LO + SEQ_BITS;
   localparam int REQ_HDL_LO  = REQ_LEN_LO + LEN_W;

   // response tdata layout, lowest bit first:
   // status, head_valid, head_seq, head_len, head_handle, count
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_ST_LO   = 0;
   localparam int RSP_HV_LO   = RSP_ST_LO + STATUS_W;
   localparam int RSP_SEQ_LO  = RSP_HV_LO + 1;
   localparam int RSP_LEN_LO  = RSP_SEQ_LO + SEQ_BITS;
   localparam int RSP_HDL_LO  = RSP_LEN_LO + LEN_W;
   localparam int RSP_CNT_LO  = RSP_HDL_LO + HANDLE_W;
   localparam int RSP_USED_W  = RSP_CNT_LO + CNT_W;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic latch;
      logic compare;
      logic update;
      logic send;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } stat_type;

endpackage

// ===== hw/rtl/srb_ctrl.sv =====
module srb_ctrl
   import srb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_UPD,
      S_SEND
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd         = '0;
      cmd.latch   = (state_ff == S_IDLE) && req_tvalid;
      cmd.compare = (state_ff == S_CMP);
      cmd.update  = (state_ff == S_UPD);
      cmd.send    = (state_ff == S_SEND) && !stat.out_busy;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_CMP;
         end
         S_CMP:  state_in = S_UPD;
         S_UPD:  state_in = S_SEND;
         S_SEND: begin
            // hold until the output register can take the result
            if (!stat.out_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/srb_datapath.sv =====
module srb_datapath
   import srb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_mode,
   input  logic [SEQ_BITS-1:0]   req_seq,
   input  logic [LEN_W-1:0]      req_len,
   input  logic [HANDLE_W-1:0]   req_handle,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_head_valid,
   output logic [SEQ_BITS-1:0]   rsp_head_seq,
   output logic [LEN_W-1:0]      rsp_head_len,
   output logic [HANDLE_W-1:0]   rsp_head_handle,
   output logic [CNT_W-1:0]      rsp_count
);

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

   // item held for the duration of its work
   logic                  mode_ff;
   logic [SEQ_BITS-1:0]   seq_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [HANDLE_W-1:0]   handle_ff;

   // sorted entries, lowest at position 0
   logic [SEQ_BITS-1:0]   entry_seq_ff    [DEPTH];
   logic [LEN_W-1:0]      entry_len_ff    [DEPTH];
   logic [HANDLE_W-1:0]   entry_handle_ff [DEPTH];
   logic [SEQ_BITS-1:0]   entry_seq_in    [DEPTH];
   logic [LEN_W-1:0]      entry_len_in    [DEPTH];
   logic [HANDLE_W-1:0]   entry_handle_in [DEPTH];
   logic [CNT_W-1:0]      count_ff, count_in;

   logic [DEPTH-1:0]      lt_ff, lt_in;
   logic [DEPTH-1:0]      eq_ff, eq_in;
   status_type            status_ff, status_in;
   logic                  do_write;

   logic                  out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]   out_status_ff;
   logic                  out_hv_ff;
   logic [SEQ_BITS-1:0]   out_seq_ff;
   logic [LEN_W-1:0]      out_len_ff;
   logic [HANDLE_W-1:0]   out_handle_ff;
   logic [CNT_W-1:0]      out_count_ff;

   // parallel compare against every held entry
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt_in[i] = (CNT_W'(i) < count_ff) && (entry_seq_ff[i] < seq_ff);
         eq_in[i] = (CNT_W'(i) < count_ff) && (entry_seq_ff[i] == seq_ff);
      end
   end

   always_comb begin
      status_in = ST_DONE;
      count_in  = count_ff;
      do_write  = 1'b0;
      if (mode_ff == MODE_INSERT) begin
         if (|eq_ff) begin
            status_in = ST_DUP;
         end else if (count_ff == CNT_W'(DEPTH)) begin
            status_in = ST_FULL;
         end else begin
            do_write = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (count_ff == '0) begin
            status_in = ST_EMPTY;
         end else begin
            do_write = 1'b1;
            count_in = count_ff - 1'b1;
         end
      end
   end

   // shift-insert or shift-down, one mux per entry
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_seq_in[i]    = entry_seq_ff[i];
         entry_len_in[i]    = entry_len_ff[i];
         entry_handle_in[i] = entry_handle_ff[i];
      end
      if (mode_ff == MODE_INSERT) begin
         if (!lt_ff[0]) begin
            entry_seq_in[0]    = seq_ff;
            entry_len_in[0]    = len_ff;
            entry_handle_in[0] = handle_ff;
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (!lt_ff[i]) begin
               if (lt_ff[i-1]) begin
                  entry_seq_in[i]    = seq_ff;
                  entry_len_in[i]    = len_ff;
                  entry_handle_in[i] = handle_ff;
               end else begin
                  entry_seq_in[i]    = entry_seq_ff[i-1];
                  entry_len_in[i]    = entry_len_ff[i-1];
                  entry_handle_in[i] = entry_handle_ff[i-1];
               end
            end
         end
      end else begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            entry_seq_in[i]    = entry_seq_ff[i+1];
            entry_len_in[i]    = entry_len_ff[i+1];
            entry_handle_in[i] = entry_handle_ff[i+1];
         end
      end
   end

   assign stat.out_busy = out_valid_ff && !rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.send) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd.update) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff   <= req_mode;
         seq_ff    <= req_seq;
         len_ff    <= (req_len > LEN_MAX) ? LEN_MAX : req_len;
         handle_ff <= req_handle;
      end
      if (cmd.compare) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      if (cmd.update) begin
         status_ff <= status_in;
         if (do_write) begin
            for (int i = 0; i < DEPTH; i++) begin
               entry_seq_ff[i]    <= entry_seq_in[i];
               entry_len_ff[i]    <= entry_len_in[i];
               entry_handle_ff[i] <= entry_handle_in[i];
            end
         end
      end
      if (cmd.send) begin
         out_status_ff <= status_ff;
         out_count_ff  <= count_ff;
         out_hv_ff     <= (count_ff != '0);
         if (count_ff != '0) begin
            out_seq_ff    <= entry_seq_ff[0];
            out_len_ff    <= entry_len_ff[0];
            out_handle_ff <= entry_handle_ff[0];
         end else begin
            out_seq_ff    <= '0;
            out_len_ff    <= '0;
            out_handle_ff <= '0;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_head_valid  = out_hv_ff;
   assign rsp_head_seq    = out_seq_ff;
   assign rsp_head_len    = out_len_ff;
   assign rsp_head_handle = out_handle_ff;
   assign rsp_count       = out_count_ff;

endmodule

// ===== hw/rtl/sorted_reorder_buffer.sv =====
// From request transfer to response valid an item passes compare, shift-insert and the
//   output register, and takes longer while the response side stalls.
// Items are taken one at a time; the compare-then-shift sequence runs once per item.
// The next request is taken while the previous response waits in its output register.
// Reset: synchronous, active high; empties the buffer and drops any pending response.
module sorted_reorder_buffer
   import srb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // seq, length, payload_handle, zero pad
   input  logic                  req_tuser,  // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status, head_valid, head_seq, head_len,
                                             // head_handle, count, zero pad
);

   cmd_type             cmd;
   stat_type            stat;
   logic [STATUS_W-1:0] status;
   logic                head_valid;
   logic [SEQ_BITS-1:0] head_seq;
   logic [LEN_W-1:0]    head_len;
   logic [HANDLE_W-1:0] head_handle;
   logic [CNT_W-1:0]    count;

   srb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   srb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_tuser),
      .req_seq         (req_tdata[REQ_SEQ_LO +: SEQ_BITS]),
      .req_len         (req_tdata[REQ_LEN_LO +: LEN_W]),
      .req_handle      (req_tdata[REQ_HDL_LO +: HANDLE_W]),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (status),
      .rsp_head_valid  (head_valid),
      .rsp_head_seq    (head_seq),
      .rsp_head_len    (head_len),
      .rsp_head_handle (head_handle),
      .rsp_count       (count)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                       count, head_handle, head_len, head_seq, head_valid, status};

endmodule

// ===== hw/rtl/srb_checker.sv =====
module srb_checker
   import srb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [CNT_W-1:0] cnt;
   logic             hv;

   assign cnt = rsp_tdata[RSP_CNT_LO +: CNT_W];
   assign hv  = rsp_tdata[RSP_HV_LO];

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hv == (cnt != '0)))
      else $error("head_valid disagrees with count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cnt <= CNT_W'(DEPTH)))
      else $error("count beyond buffer depth");

   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !hv |-> (rsp_tdata[RSP_CNT_LO-1:RSP_SEQ_LO] == '0))
      else $error("empty buffer reports a non-zero head");

endmodule

bind sorted_reorder_buffer srb_checker u_srb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
